FILE: rtl/psort_pkg.sv
`default_nettype none

package psort_pkg;

	// Default buffer depth and the width of one value.
	localparam int DEPTH_DEF = 64;
	localparam int VAL_W     = 32;

	// Signed value as it is stored and compared.
	typedef logic signed [VAL_W-1:0] val_t;

endpackage

`default_nettype wire

FILE: rtl/pairwise_insertion_sorter.sv
`default_nettype none
// A value is inserted into the sorted buffer as it arrives: written directly into an
// empty buffer, dropped at a full one, else the input stalls while each larger entry is
// shifted up one place, one write per shifted entry, and the value goes into the gap.
// After the item marked last, results leave in order from the buffer read port.
// Reset clears the fill count, the overflow flag and the output register valid;
// the buffer contents are not cleared and need no clearing pass.
module pairwise_insertion_sorter #(
	parameter int DEPTH = psort_pkg::DEPTH_DEF
) (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             in_valid,
	output logic            in_stall,
	input  psort_pkg::val_t value,
	input  wire             last,
	output logic            out_valid,
	input  wire             out_stall,
	output psort_pkg::val_t sorted_value,
	output logic            end_of_run,
	output logic            overflow
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_INS  = 3'd1;
	localparam logic [2:0] ST_WRZ  = 3'd2;
	localparam logic [2:0] ST_ERD  = 3'd3;
	localparam logic [2:0] ST_ELD  = 3'd4;

	logic [2:0]      state_q;
	logic [CW-1:0]   fill_q;
	logic            drop_q;
	logic [AW-1:0]   pos_q;
	logic [AW-1:0]   idx_q;
	psort_pkg::val_t key_q;
	logic            last_q;

	logic            out_valid_q;
	psort_pkg::val_t out_value_q;
	logic            out_end_q;
	logic            out_ovf_q;

	logic            mem_we;
	logic [AW-1:0]   mem_waddr;
	psort_pkg::val_t mem_wdata;
	logic [AW-1:0]   mem_raddr;
	psort_pkg::val_t mem_rdata;

	logic            in_acc;
	logic            out_acc;
	logic            out_free;
	logic            full;
	logic            shift_up;
	logic            run_end;

	psort_mem #(
		.DEPTH(DEPTH)
	) u_mem (
		.clk  (clk),
		.we   (mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign out_acc   = out_valid_q && !out_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign full      = (fill_q == CW'(DEPTH));
	assign shift_up  = (mem_rdata > key_q);
	assign run_end   = ((CW'(idx_q) + CW'(1)) == fill_q);

	// Buffer port control: write into an empty buffer, shift the larger entries up and insert the key, or read out.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		mem_wdata = key_q;
		mem_raddr = idx_q;
		unique case (state_q)
			ST_IDLE: begin
				mem_waddr = '0;
				mem_wdata = value;
				mem_raddr = AW'(fill_q - CW'(1));
				mem_we    = in_acc && (fill_q == '0);
			end
			ST_INS: begin
				mem_we    = 1'b1;
				mem_wdata = shift_up ? mem_rdata : key_q;
				mem_raddr = pos_q - AW'(2);
			end
			ST_WRZ: begin
				mem_we    = 1'b1;
				mem_waddr = '0;
			end
			ST_ERD, ST_ELD: begin
				mem_raddr = idx_q;
			end
			default: begin
				mem_raddr = idx_q;
			end
		endcase
	end

	// Sequencer for loading, insertion and read-out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q  <= '0;
			drop_q  <= 1'b0;
			pos_q   <= '0;
			idx_q   <= '0;
			last_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						key_q  <= value;
						last_q <= last;
						idx_q  <= '0;
						if (full) begin
							drop_q <= 1'b1;
							if (last) begin
								state_q <= ST_ERD;
							end
						end else begin
							fill_q <= fill_q + CW'(1);
							pos_q  <= AW'(fill_q);
							if (fill_q != '0) begin
								state_q <= ST_INS;
							end else if (last) begin
								state_q <= ST_ERD;
							end
						end
					end
				end
				ST_INS: begin
					if (shift_up) begin
						pos_q <= pos_q - AW'(1);
						if (pos_q == AW'(1)) begin
							state_q <= ST_WRZ;
						end
					end else begin
						state_q <= last_q ? ST_ERD : ST_IDLE;
					end
				end
				ST_WRZ: begin
					state_q <= last_q ? ST_ERD : ST_IDLE;
				end
				ST_ERD: begin
					if (out_free) begin
						state_q <= ST_ELD;
					end
				end
				ST_ELD: begin
					if (run_end) begin
						fill_q  <= '0;
						drop_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else begin
						idx_q   <= idx_q + AW'(1);
						state_q <= ST_ERD;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register; it holds a result while the next set loads.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_ELD) begin
			out_valid_q <= 1'b1;
		end else if (out_acc) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_ELD) begin
			out_value_q <= mem_rdata;
			out_end_q   <= run_end;
			out_ovf_q   <= drop_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign sorted_value = out_value_q;
	assign end_of_run   = out_end_q;
	assign overflow     = out_ovf_q;

	// The fill count never passes the buffer depth.
	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= CW'(DEPTH))
		else $error("fill count above depth");

	// A dropped value is only possible with a full buffer.
	a_drop_full: assert property (@(posedge clk) disable iff (!arst_n)
		drop_q |-> full)
		else $error("overflow flag without full buffer");

	// Insertion walks only over stored entries and never reaches entry zero.
	a_ins_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_INS) |-> (pos_q != '0) && (CW'(pos_q) < fill_q))
		else $error("insertion position out of range");

	// A result is loaded only into an empty output register.
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELD) |-> !out_valid_q)
		else $error("output register overwritten");

	// The final result of a set empties the buffer and clears the flag.
	a_run_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_ELD) && run_end |=> (fill_q == '0) && !drop_q)
		else $error("buffer not cleared after the set");

endmodule

`default_nettype wire

FILE: rtl/psort_mem.sv
`default_nettype none

// Value buffer: one write port and one read port, with a registered read.
module psort_mem #(
	parameter int DEPTH = psort_pkg::DEPTH_DEF,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire                  clk,
	input  wire                  we,
	input  wire [AW-1:0]         waddr,
	input  psort_pkg::val_t      wdata,
	input  wire [AW-1:0]         raddr,
	output psort_pkg::val_t      rdata
);

	psort_pkg::val_t mem_q [DEPTH];
	psort_pkg::val_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port; the data is registered, so it appears in the cycle after the address.
	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

FILE: tb/sv/pairwise_insertion_sorter_tb.sv
`default_nettype none

module pairwise_insertion_sorter_tb;

	typedef psort_pkg::val_t val_t;

	localparam int DEPTH = psort_pkg::DEPTH_DEF;
	localparam int IDLE_LIMIT = 2000;
	localparam int RANDOM_ITEMS = 120;
	localparam val_t VAL_MIN = 32'h8000_0000;
	localparam val_t VAL_MAX = 32'h7FFF_FFFF;

	typedef struct {
		val_t sorted_value;
		logic end_of_run;
		logic overflow;
	} sorted_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	val_t value = '0;
	logic last = 1'b0;
	logic out_stall = 1'b0;
	logic in_stall;
	logic out_valid;
	val_t sorted_value;
	logic end_of_run;
	logic overflow;

	// Values of the set being loaded, and the sorted results still to come.
	val_t set_values[$];
	bit set_overflowed = 1'b0;
	sorted_result_t expected_sorted[$];

	int error_count = 0;
	int idle_cycles = 0;
	bit no_idle = 1'b0;

	always #5 clk = ~clk;

	pairwise_insertion_sorter #(
		.DEPTH(DEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.value(value),
		.last(last),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.sorted_value(sorted_value),
		.end_of_run(end_of_run),
		.overflow(overflow)
	);

	// Keep an accepted value that fits; on a set's final value, sort it and queue results.
	function automatic void load_value(input val_t v, input logic l);
		val_t ordered[$];
		val_t key;
		int j;
		sorted_result_t r;
		if (set_values.size() < DEPTH)
			set_values = {set_values, v};
		else
			set_overflowed = 1'b1;
		if (l) begin
			ordered = set_values;
			for (int i = 1; i < ordered.size(); i++) begin
				key = ordered[i];
				j = i;
				while (j > 0 && ordered[j - 1] > key) begin
					ordered[j] = ordered[j - 1];
					j--;
				end
				ordered[j] = key;
			end
			for (int i = 0; i < ordered.size(); i++) begin
				r.sorted_value = ordered[i];
				r.end_of_run = (i == ordered.size() - 1);
				r.overflow = set_overflowed;
				expected_sorted = {expected_sorted, r};
			end
			set_values.delete();
			set_overflowed = 1'b0;
		end
	endfunction

	// Number of idle cycles before the next transaction on either side.
	function automatic int pick_wait();
		if (no_idle || $urandom_range(0, 3) == 0)
			return 0;
		return $urandom_range(0, 15);
	endfunction

	function automatic val_t random_value();
		case ($urandom_range(0, 9))
			0, 1, 2, 3: return val_t'($urandom);
			4, 5, 6: return val_t'(int'($urandom_range(0, 8)) - 4);
			7: return VAL_MIN;
			8: return VAL_MAX;
			default: return val_t'($urandom_range(0, 255));
		endcase
	endfunction

	// Send one transaction; called and returning at a falling edge.
	task automatic send_value(input val_t v, input logic l);
		int gap;
		gap = pick_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		value <= v;
		last <= l;
		do @(posedge clk); while (in_stall !== 1'b0);
		load_value(v, l);
		@(negedge clk);
	endtask

	task automatic send_set(input val_t vals[$]);
		for (int i = 0; i < vals.size(); i++)
			send_value(vals[i], i == vals.size() - 1);
	endtask

	// Hold off the input until every queued result has been received.
	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (expected_sorted.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	task automatic test_single_value();
		val_t vals[$];
		vals = '{VAL_MIN};
		send_set(vals);
	endtask

	task automatic test_field_extremes();
		val_t vals[$];
		vals = '{VAL_MAX, VAL_MIN, 32'sd0, -32'sd1, 32'sd1, 32'sh7FFF_FFFE, 32'sh8000_0001};
		send_set(vals);
		vals = '{VAL_MAX, VAL_MIN};
		send_set(vals);
	endtask

	task automatic test_equal_values();
		val_t vals[$];
		vals = '{32'sd5, -32'sd3, 32'sd5, 32'sd5, -32'sd3, 32'sd0};
		send_set(vals);
	endtask

	task automatic test_descending_run();
		val_t vals[$];
		for (int i = 0; i < 8; i++)
			vals = {vals, val_t'(1000 - 300 * i)};
		send_set(vals);
		wait_for_drain();
	endtask

	// Exactly fills the buffer, so no value is dropped.
	task automatic test_full_buffer();
		val_t vals[$];
		for (int i = 0; i < DEPTH; i++)
			vals = {vals, random_value()};
		send_set(vals);
	endtask

	// Values past the buffer depth are dropped, the final one included.
	task automatic test_buffer_overflow();
		val_t vals[$];
		for (int i = 0; i < DEPTH + 3; i++)
			vals = {vals, random_value()};
		send_set(vals);
		wait_for_drain();
	endtask

	// Random sets, mostly small, with a few at or beyond the buffer depth.
	task automatic test_random_sets();
		val_t vals[$];
		int sent;
		int set_size;
		int pick;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 19);
			if (pick < 14)
				set_size = $urandom_range(1, 10);
			else if (pick < 18)
				set_size = $urandom_range(11, 40);
			else if (pick == 18)
				set_size = DEPTH;
			else
				set_size = $urandom_range(DEPTH + 1, DEPTH + 6);
			vals.delete();
			for (int i = 0; i < set_size; i++)
				vals = {vals, random_value()};
			no_idle = ($urandom_range(0, 4) == 0);
			send_set(vals);
			sent += set_size;
			if ($urandom_range(0, 3) == 0)
				wait_for_drain();
		end
		no_idle = 1'b0;
	endtask

	// Receive results with random stalls and compare each with the oldest expectation.
	initial begin : result_checker
		int stall_cycles;
		sorted_result_t exp_r;
		wait (arst_n === 1'b1);
		@(negedge clk);
		forever begin
			stall_cycles = pick_wait();
			if (stall_cycles > 0) begin
				out_stall <= 1'b1;
				repeat (stall_cycles) @(negedge clk);
			end
			out_stall <= 1'b0;
			do @(posedge clk); while (out_valid !== 1'b1);
			if (expected_sorted.size() == 0) begin
				$error("unexpected result transaction: sorted_value=%0d", sorted_value);
				error_count++;
			end else begin
				exp_r = expected_sorted.pop_front();
				if (sorted_value !== exp_r.sorted_value) begin
					$error("sorted_value: expected %0d, got %0d", exp_r.sorted_value,
						sorted_value);
					error_count++;
				end
				if (end_of_run !== exp_r.end_of_run) begin
					$error("end_of_run: expected %0b, got %0b", exp_r.end_of_run, end_of_run);
					error_count++;
				end
				if (overflow !== exp_r.overflow) begin
					$error("overflow: expected %0b, got %0b", exp_r.overflow, overflow);
					error_count++;
				end
			end
			@(negedge clk);
		end
	end

	// Watchdog: end the run when no transaction moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid === 1'b1 && in_stall === 1'b0) ||
					(out_valid === 1'b1 && out_stall === 1'b0))
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("[FAIL] regression broken");
				$finish;
			end
		end
	end

	// Reset, run every test in turn, then drain and report.
	initial begin
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_single_value();
		test_field_extremes();
		test_equal_values();
		test_descending_run();
		test_full_buffer();
		test_buffer_overflow();
		test_random_sets();
		in_valid <= 1'b0;
		while (expected_sorted.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire
